@@ rtl/core/apc_pkg.sv @@
package apc_pkg;

   // Field widths of one box pair and of one result.
   localparam int CTR_W  = 32;          // center, Q16.16 signed
   localparam int SIZE_W = 31;          // full size, Q15.16 unsigned
   localparam int HALF_W = SIZE_W - 1;  // half size after the shift
   localparam int EXT_W  = CTR_W + 1;   // box extent, signed
   localparam int DIFF_W = CTR_W + 2;   // extent difference, signed
   localparam int NRM_W  = 2;           // normal sign, signed
   localparam int NUM_AXES = 3;

   localparam int REQ_TDATA_W = 384;
   localparam int RSP_TDATA_W = 48;

   // Sign codes of a normal component.
   localparam logic [NRM_W-1:0] SIGN_ZERO = 2'b00;
   localparam logic [NRM_W-1:0] SIGN_POS  = 2'b01;
   localparam logic [NRM_W-1:0] SIGN_NEG  = 2'b11;

   // Contact axis codes.
   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;
   localparam logic [1:0] AXIS_Z = 2'd2;

   // Load enables of the three lane stages.
   typedef struct packed {
      logic en1;
      logic en2;
      logic en3;
   } apc_adv_type;

endpackage

@@ rtl/core/apc_lane.sv @@
module apc_lane
   import apc_pkg::*;
(
   input  logic                     clock,
   input  apc_adv_type              adv,
   input  logic signed [CTR_W-1:0]  a_center,
   input  logic        [SIZE_W-1:0] a_size,
   input  logic signed [CTR_W-1:0]  b_center,
   input  logic        [SIZE_W-1:0] b_size,
   output logic signed [DIFF_W-1:0] overlap,
   output logic        [DIFF_W-1:0] magnitude,
   output logic        [NRM_W-1:0]  sign
);

   // Stage 1: box extents on this axis.
   logic signed [EXT_W-1:0] a_max_in, a_min_in, b_max_in, b_min_in, b_ctr_in;
   logic signed [EXT_W-1:0] a_max_ff, a_min_ff, b_max_ff, b_min_ff, b_ctr_ff;
   logic signed [EXT_W-1:0] a_half_ext, b_half_ext;

   always_comb begin
      a_half_ext = $signed({{(EXT_W-HALF_W){1'b0}}, a_size[SIZE_W-1:1]});
      b_half_ext = $signed({{(EXT_W-HALF_W){1'b0}}, b_size[SIZE_W-1:1]});
      a_max_in   = $signed({a_center[CTR_W-1], a_center}) + a_half_ext;
      a_min_in   = $signed({a_center[CTR_W-1], a_center}) - a_half_ext;
      b_ctr_in   = $signed({b_center[CTR_W-1], b_center});
      b_max_in   = b_ctr_in + b_half_ext;
      b_min_in   = b_ctr_in - b_half_ext;
   end

   always_ff @(posedge clock) begin
      if (adv.en1) begin
         a_max_ff <= a_max_in;
         a_min_ff <= a_min_in;
         b_max_ff <= b_max_in;
         b_min_ff <= b_min_in;
         b_ctr_ff <= b_ctr_in;
      end
   end

   // Stage 2: the two cross differences and the offset of B's center
   // from its clamp into A.
   logic signed [DIFF_W-1:0] ov_p_in, ov_q_in, dist_in;
   logic signed [DIFF_W-1:0] ov_p_ff, ov_q_ff, dist_ff;

   always_comb begin
      ov_p_in = $signed({a_max_ff[EXT_W-1], a_max_ff}) - $signed({b_min_ff[EXT_W-1], b_min_ff});
      ov_q_in = $signed({b_max_ff[EXT_W-1], b_max_ff}) - $signed({a_min_ff[EXT_W-1], a_min_ff});
      priority if (b_ctr_ff < a_min_ff) begin
         dist_in = $signed({b_ctr_ff[EXT_W-1], b_ctr_ff})
                 - $signed({a_min_ff[EXT_W-1], a_min_ff});
      end else if (b_ctr_ff > a_max_ff) begin
         dist_in = $signed({b_ctr_ff[EXT_W-1], b_ctr_ff})
                 - $signed({a_max_ff[EXT_W-1], a_max_ff});
      end else begin
         dist_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv.en2) begin
         ov_p_ff <= ov_p_in;
         ov_q_ff <= ov_q_in;
         dist_ff <= dist_in;
      end
   end

   // Stage 3: overlap, offset magnitude and offset sign.
   logic signed [DIFF_W-1:0] overlap_in, overlap_ff;
   logic        [DIFF_W-1:0] mag_in, mag_ff;
   logic        [NRM_W-1:0]  sign_in, sign_ff;

   always_comb begin
      overlap_in = (ov_p_ff < ov_q_ff) ? ov_p_ff : ov_q_ff;
      mag_in     = dist_ff[DIFF_W-1] ? $unsigned(-dist_ff) : $unsigned(dist_ff);
      priority if (dist_ff[DIFF_W-1]) begin
         sign_in = SIGN_NEG;
      end else if (dist_ff != '0) begin
         sign_in = SIGN_POS;
      end else begin
         sign_in = SIGN_ZERO;
      end
   end

   always_ff @(posedge clock) begin
      if (adv.en3) begin
         overlap_ff <= overlap_in;
         mag_ff     <= mag_in;
         sign_ff    <= sign_in;
      end
   end

   assign overlap   = overlap_ff;
   assign magnitude = mag_ff;
   assign sign      = sign_ff;

endmodule

@@ rtl/core/aabb_pair_collision.sv @@
// Overlap test of two axis-aligned boxes, one box pair per request.
//
// The req_ channel carries both boxes as centers in Q16.16 and full sizes in Q15.16.
// The rsp_ channel returns one result per request: the hit flag, the
// contact normal as three sign codes and the penetration on the contact
// axis. Requests and results pair up strictly in order.
//
// Three lane stages (extents, cross differences and clamp offset, overlap
// and magnitude) run side by side for x, y and z, and a fourth stage picks
// the contact axis into the output register, which drives rsp_tvalid.
// Throughput is one request per cycle while the receiver keeps rsp_tready
// high, set by the four pipeline registers, each of which takes a new
// entry in every cycle in which it is not stalled.
//
// When the receiver holds rsp_tready low the result stays in the output
// register and the pipeline fills behind it; req_tready drops only once
// every stage holds a request. Synchronous reset empties the pipeline.
module aabb_pair_collision
   import apc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // From bit 0: a_center_x, a_center_y, a_center_z (32 each),
   // a_size_x, a_size_y, a_size_z (31 each), b_center_x, b_center_y,
   // b_center_z (32 each), b_size_x, b_size_y, b_size_z (31 each), zeros.
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // From bit 0: hit (1), normal_x, normal_y, normal_z (2 each),
   // penetration (34), zeros.
   output logic [RSP_TDATA_W-1:0] rsp_tdata
);

   // Field offsets within req_tdata.
   localparam int A_CTR_LSB  = 0;
   localparam int A_SIZE_LSB = A_CTR_LSB + NUM_AXES * CTR_W;
   localparam int B_CTR_LSB  = A_SIZE_LSB + NUM_AXES * SIZE_W;
   localparam int B_SIZE_LSB = B_CTR_LSB + NUM_AXES * CTR_W;
   localparam int RSP_USED_W = 1 + NUM_AXES * NRM_W + DIFF_W;

   // Stage occupancy and flow control. A stage may load when it is empty
   // or when its content moves on in the same cycle.
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic s1_free, s2_free, s3_free, out_free;
   logic en4;
   apc_adv_type adv;

   always_comb begin
      out_free = !v4_ff || rsp_tready;
      s3_free  = !v3_ff || out_free;
      s2_free  = !v2_ff || s3_free;
      s1_free  = !v1_ff || s2_free;
      adv.en1  = req_tvalid && s1_free;
      adv.en2  = v1_ff && s2_free;
      adv.en3  = v2_ff && s3_free;
      en4      = v3_ff && out_free;
   end

   assign req_tready = s1_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (s1_free) begin
            v1_ff <= req_tvalid;
         end
         if (s2_free) begin
            v2_ff <= v1_ff;
         end
         if (s3_free) begin
            v3_ff <= v2_ff;
         end
         if (out_free) begin
            v4_ff <= v3_ff;
         end
      end
   end

   // One lane per axis covers the first three stages.
   logic signed [DIFF_W-1:0] overlap [NUM_AXES];
   logic        [DIFF_W-1:0] mag     [NUM_AXES];
   logic        [NRM_W-1:0]  sgn     [NUM_AXES];

   for (genvar i = 0; i < NUM_AXES; i++) begin : g_lane
      apc_lane u_lane (
         .clock     (clock),
         .adv       (adv),
         .a_center  ($signed(req_tdata[A_CTR_LSB + i*CTR_W +: CTR_W])),
         .a_size    (req_tdata[A_SIZE_LSB + i*SIZE_W +: SIZE_W]),
         .b_center  ($signed(req_tdata[B_CTR_LSB + i*CTR_W +: CTR_W])),
         .b_size    (req_tdata[B_SIZE_LSB + i*SIZE_W +: SIZE_W]),
         .overlap   (overlap[i]),
         .magnitude (mag[i]),
         .sign      (sgn[i])
      );
   end

   // Stage 4: contact axis, hit and normal. The axis is x when its offset
   // is strictly the larger of x and y, otherwise y, and z takes over only
   // when its offset is strictly larger than the one chosen so far. A box
   // B centered inside A therefore reports the y axis with a zero normal.
   logic [1:0]               axis_xy, axis_sel;
   logic [DIFF_W-1:0]        mag_xy;
   logic                     hit_in;
   logic [NRM_W-1:0]         nrm_in [NUM_AXES];
   logic signed [DIFF_W-1:0] pen_in;

   logic                     hit_ff;
   logic [NRM_W-1:0]         nrm_ff [NUM_AXES];
   logic signed [DIFF_W-1:0] pen_ff;

   always_comb begin
      if (mag[0] > mag[1]) begin
         axis_xy = AXIS_X;
         mag_xy  = mag[0];
      end else begin
         axis_xy = AXIS_Y;
         mag_xy  = mag[1];
      end
      axis_sel = (mag_xy < mag[2]) ? AXIS_Z : axis_xy;
      hit_in   = (overlap[0] > 0) && (overlap[1] > 0) && (overlap[2] > 0);
      unique case (axis_sel)
         AXIS_X:  pen_in = overlap[0];
         AXIS_Y:  pen_in = overlap[1];
         AXIS_Z:  pen_in = overlap[2];
         default: pen_in = overlap[2];
      endcase
      for (int i = 0; i < NUM_AXES; i++) begin
         nrm_in[i] = (hit_in && axis_sel == 2'(i)) ? sgn[i] : SIGN_ZERO;
      end
   end

   always_ff @(posedge clock) begin
      if (en4) begin
         hit_ff <= hit_in;
         pen_ff <= pen_in;
         for (int i = 0; i < NUM_AXES; i++) begin
            nrm_ff[i] <= nrm_in[i];
         end
      end
   end

   assign rsp_tvalid = v4_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W-RSP_USED_W){1'b0}}, pen_ff,
                        nrm_ff[2], nrm_ff[1], nrm_ff[0], hit_ff};

`ifndef SYNTHESIS
   // A pipeline stage never drops a request it has just accepted.
   a_req_lands: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> v1_ff)
      else $error("accepted request did not reach the first stage");

   // A result without a hit carries a zero normal.
   a_miss_zero_normal: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tdata[0]) |-> (rsp_tdata[6:1] == '0))
      else $error("normal is nonzero on a result without a hit");

   // At most one axis of the normal is set, and no code is the unused one.
   a_single_axis: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($countones({rsp_tdata[1], rsp_tdata[3], rsp_tdata[5]}) <= 1
                      && rsp_tdata[2:1] != 2'b10 && rsp_tdata[4:3] != 2'b10
                      && rsp_tdata[6:5] != 2'b10))
      else $error("normal is set on more than one axis or holds a bad code");

   // A stalled stage keeps the next stage full rather than losing content.
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (v3_ff && v4_ff && !rsp_tready) |=> (v3_ff && v4_ff))
      else $error("pipeline lost a request under a stall");

   // Reset empties the pipeline.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!rsp_tvalid && !v1_ff && !v2_ff && !v3_ff))
      else $error("pipeline not empty after reset");
`endif

endmodule
